/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

/* hdl/rbw_pkg.sv */
// ----------------------------------------------------------------------------
// rbw_pkg
// Shared types, constants and helpers of the rigid body warmstart pipeline.
// ----------------------------------------------------------------------------
package rbw_pkg;

  localparam int Q_BITS = 16;

  localparam logic [16:0] DT_RESET     = 17'd1092;
  localparam logic [30:0] INV_DT_RESET = 31'd3932160;

  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_INV_TIME_STEP = 2'd1;

  localparam logic signed [31:0] ANG_LIMIT = 32'sd3276800;

  // Payload carried alongside the divider.
  typedef struct packed {
    logic signed [51:0] base_x;
    logic signed [51:0] base_y;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [31:0]        warm_a;
    logic [31:0]        inert_x;
    logic [31:0]        inert_y;
    logic [22:0]        cav;
    logic               last;
  } carry_t;

  // One divider lane: partial remainder, divisor, quotient and weight flags.
  typedef struct packed {
    logic [47:0] rem;
    logic [31:0] mag;
    logic [15:0] q;
    logic        zero;
    logic        one;
  } div_lane_t;

  // Round half up at bit 16, floor, saturate to 32 bit signed.
  function automatic logic [31:0] sat_round(input logic signed [55:0] x);
    logic signed [55:0] t;
    t = (x + 56'sd32768) >>> 16;
    if (t > 56'sd2147483647) return 32'h7fff_ffff;
    else if (t < -56'sd2147483648) return 32'h8000_0000;
    else return t[31:0];
  endfunction

endpackage

/* hdl/rigid_body_warmstart.sv */
// ----------------------------------------------------------------------------
// rigid_body_warmstart
// Per-body inertial and adaptively warmstarted pose, Q16.16, saturating.
// ----------------------------------------------------------------------------
// One body enters per cycle unless the output stalls; its result passes 3 front
// stages, 16 divider stages and 3 back stages including the output register,
// sustained one transaction per clock. The depth is set by the weight divider,
// which resolves one quotient bit per stage. The whole pipe advances as one: it
// moves whenever the output register is empty or being taken, so an output
// stall freezes every stage and nothing is dropped or repeated. time_step and
// inverse_time_step must be written through the cfg channel only while the pipe
// is empty; the block does not enforce it. dt^2 updates the cycle after a write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rigid_body_warmstart (
  input  logic         clk,
  input  logic         rst,
  // input bodies
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_angle, vel_x, vel_y, vel_angle, prev_vel_x,
  // prev_vel_y, gravity_x, gravity_y (32 bits each, low to high)
  input  logic [319:0] s_tdata,
  input  logic         s_tuser,   // mass_positive
  input  logic         s_tlast,   // last_body
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  // warm_x, warm_y, warm_angle, inertial_x, inertial_y, inertial_angle
  // (32 bits each), clamped_ang_vel (23 bits), one pad bit, low to high
  output logic [215:0] m_tdata,
  output logic         m_tlast,   // last_out
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import rbw_pkg::*;

  logic en;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Config registers; unknown indexes are ignored.
  logic [16:0] dt;
  logic [30:0] inv_dt;
  logic [18:0] dt2;
  logic [33:0] dtsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt     <= DT_RESET;
      inv_dt <= INV_DT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIME_STEP:     dt     <= cfg_data[16:0];
        REG_INV_TIME_STEP: inv_dt <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // dt^2 rounded to Q16.16
  assign dtsq = dt * dt;
  always_ff @(posedge clk) begin
    dt2 <= 19'((35'(dtsq) + 35'd32768) >> 16);
  end

  logic                 f_valid, d_valid;
  carry_t               f_carry, d_carry;
  div_lane_t [1:0]      f_lane, d_lane;

  rbw_front u_front (
    .clk, .rst, .en,
    .in_valid (s_tvalid && s_tready),
    .in_data  (s_tdata),
    .in_mass  (s_tuser),
    .in_last  (s_tlast),
    .dt, .dt2, .inv_dt,
    .out_valid (f_valid),
    .out_carry (f_carry),
    .out_lane  (f_lane)
  );

  rbw_div u_div (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .in_carry  (f_carry),
    .in_lane   (f_lane),
    .out_valid (d_valid),
    .out_carry (d_carry),
    .out_lane  (d_lane)
  );

  rbw_back u_back (
    .clk, .rst, .en,
    .in_valid  (d_valid),
    .in_carry  (d_carry),
    .in_lane   (d_lane),
    .dt2,
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

  logic signed [22:0] m_cav;
  assign m_cav = m_tdata[214:192];

  // Pipe moves exactly when the output slot frees.
  `ASSERT_CLK(a_ready_tracks_out, clk, rst, s_tready == (!m_tvalid || m_tready))
  // Angle has no gravity term, so both angle results agree.
  `ASSERT_CLK(a_angle_match, clk, rst, m_tvalid |-> (m_tdata[95:64] == m_tdata[191:160]))
  // Clamped angular velocity stays within plus or minus 50.
  `ASSERT_CLK(a_cav_range, clk, rst, m_tvalid |-> (m_cav <= 23'sd3276800 && m_cav >= -23'sd3276800))

endmodule

/* hdl/rbw_front.sv */
// ----------------------------------------------------------------------------
// rbw_front
// Three stages: differences and clamp, products, base sums and divider setup.
// ----------------------------------------------------------------------------
module rbw_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [319:0]           in_data,
  input  logic                   in_mass,
  input  logic                   in_last,
  input  logic [16:0]            dt,
  input  logic [18:0]            dt2,
  input  logic [30:0]            inv_dt,
  output logic                   out_valid,
  output rbw_pkg::carry_t        out_carry,
  output rbw_pkg::div_lane_t [1:0] out_lane
);
  import rbw_pkg::*;

  logic signed [31:0] px, py, pa, vx, vy, va, pvx, pvy, gx, gy;
  assign px  = in_data[31:0];
  assign py  = in_data[63:32];
  assign pa  = in_data[95:64];
  assign vx  = in_data[127:96];
  assign vy  = in_data[159:128];
  assign va  = in_data[191:160];
  assign pvx = in_data[223:192];
  assign pvy = in_data[255:224];
  assign gx  = in_data[287:256];
  assign gy  = in_data[319:288];

  // stage 1
  logic v1;
  logic signed [31:0] px1, py1, pa1, vx1, vy1, gx1, gy1;
  logic signed [22:0] vac1;
  logic signed [33:0] dpx1, dpy1;
  logic [31:0] magx1, magy1;
  logic mass1, last1;

  logic signed [32:0] dx, dy;
  logic signed [31:0] vac;
  assign dx = {vx[31], vx} - {pvx[31], pvx};
  assign dy = {vy[31], vy} - {pvy[31], pvy};
  always_comb begin
    if (va > ANG_LIMIT) vac = ANG_LIMIT;
    else if (va < -ANG_LIMIT) vac = -ANG_LIMIT;
    else vac = va;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= px; py1 <= py; pa1 <= pa; vx1 <= vx; vy1 <= vy;
      gx1 <= gx; gy1 <= gy;
      vac1  <= vac[22:0];
      // sign of g folded into the difference
      dpx1  <= gx[31] ? -{dx[32], dx} : {dx[32], dx};
      dpy1  <= gy[31] ? -{dy[32], dy} : {dy[32], dy};
      magx1 <= gx[31] ? (~gx + 32'd1) : gx;
      magy1 <= gy[31] ? (~gy + 32'd1) : gy;
      mass1 <= in_mass;
      last1 <= in_last;
    end
  end

  // stage 2
  logic v2;
  logic signed [31:0] px2, py2, pa2, gx2, gy2;
  logic signed [22:0] vac2;
  logic [63:0] numx2, numy2;
  logic posx2, posy2;
  logic [31:0] magx2, magy2;
  logic signed [49:0] vxdt2, vydt2;
  logic signed [40:0] vadt2;
  logic signed [51:0] gixdt2, giydt2;
  logic last2;

  logic signed [31:0] gix, giy;
  logic signed [17:0] dt_s;
  logic signed [19:0] dt2_s;
  assign gix   = mass1 ? gx1 : 32'sd0;
  assign giy   = mass1 ? gy1 : 32'sd0;
  assign dt_s  = $signed({1'b0, dt});
  assign dt2_s = $signed({1'b0, dt2});

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= px1; py2 <= py1; pa2 <= pa1; gx2 <= gx1; gy2 <= gy1;
      vac2  <= vac1;
      numx2 <= (dpx1 > 34'sd0) ? 64'(dpx1[32:0] * inv_dt) : 64'd0;
      numy2 <= (dpy1 > 34'sd0) ? 64'(dpy1[32:0] * inv_dt) : 64'd0;
      posx2 <= (dpx1 > 34'sd0) && (magx1 != 32'd0);
      posy2 <= (dpy1 > 34'sd0) && (magy1 != 32'd0);
      magx2 <= magx1;
      magy2 <= magy1;
      vxdt2 <= vx1 * dt_s;
      vydt2 <= vy1 * dt_s;
      vadt2 <= vac1 * dt_s;
      gixdt2 <= gix * dt2_s;
      giydt2 <= giy * dt2_s;
      last2 <= last1;
    end
  end

  // stage 3
  logic signed [51:0] bx, by;
  logic signed [55:0] ba;
  assign bx = {{4{px2[31]}}, px2, 16'b0} + 52'(vxdt2);
  assign by = {{4{py2[31]}}, py2, 16'b0} + 52'(vydt2);
  assign ba = {{8{pa2[31]}}, pa2, 16'b0} + 56'(vadt2);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_carry.base_x  <= bx;
      out_carry.base_y  <= by;
      out_carry.gx      <= gx2;
      out_carry.gy      <= gy2;
      out_carry.warm_a  <= sat_round(ba);
      out_carry.inert_x <= sat_round(56'(bx) + 56'(gixdt2));
      out_carry.inert_y <= sat_round(56'(by) + 56'(giydt2));
      out_carry.cav     <= vac2;
      out_carry.last    <= last2;
      out_lane[0].rem  <= numx2[47:0];
      out_lane[0].mag  <= magx2;
      out_lane[0].q    <= '0;
      out_lane[0].zero <= !posx2 || (numx2 == 64'd0);
      out_lane[0].one  <= numx2 >= {16'b0, magx2, 16'b0};
      out_lane[1].rem  <= numy2[47:0];
      out_lane[1].mag  <= magy2;
      out_lane[1].q    <= '0;
      out_lane[1].zero <= !posy2 || (numy2 == 64'd0);
      out_lane[1].one  <= numy2 >= {16'b0, magy2, 16'b0};
    end
  end

endmodule

/* hdl/rbw_div.sv */
// ----------------------------------------------------------------------------
// rbw_div
// Restoring divider, one quotient bit per stage, two lanes, payload alongside.
// ----------------------------------------------------------------------------
module rbw_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  rbw_pkg::carry_t          in_carry,
  input  rbw_pkg::div_lane_t [1:0] in_lane,
  output logic                     out_valid,
  output rbw_pkg::carry_t          out_carry,
  output rbw_pkg::div_lane_t [1:0] out_lane
);
  import rbw_pkg::*;

  logic                  vld   [0:Q_BITS];
  carry_t                carry [0:Q_BITS];
  div_lane_t [1:0]       lane  [0:Q_BITS];

  assign vld[0]   = in_valid;
  assign carry[0] = in_carry;
  assign lane[0]  = in_lane;

  for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
    localparam int K = Q_BITS - 1 - s;
    div_lane_t [1:0] nxt;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [48:0] trial;
      assign trial = {1'b0, lane[s][l].rem} - ({17'b0, lane[s][l].mag} << K);
      always_comb begin
        nxt[l] = lane[s][l];
        if (!trial[48]) begin
          nxt[l].rem  = trial[47:0];
          nxt[l].q[K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (en) vld[s+1] <= vld[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        carry[s+1] <= carry[s];
        lane[s+1]  <= nxt;
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign out_carry = carry[Q_BITS];
  assign out_lane  = lane[Q_BITS];

endmodule

/* hdl/rbw_back.sv */
// ----------------------------------------------------------------------------
// rbw_back
// Weight select and gravity scaling, dt^2 product, final sum and output register.
// ----------------------------------------------------------------------------
module rbw_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  rbw_pkg::carry_t          in_carry,
  input  rbw_pkg::div_lane_t [1:0] in_lane,
  input  logic [18:0]              dt2,
  output logic                     out_valid,
  output logic [215:0]             out_data,
  output logic                     out_last
);
  import rbw_pkg::*;

  logic [16:0] wx, wy;
  always_comb begin
    if (in_lane[0].zero) wx = 17'd0;
    else if (in_lane[0].one) wx = 17'h10000;
    else wx = {1'b0, in_lane[0].q};
    if (in_lane[1].zero) wy = 17'd0;
    else if (in_lane[1].one) wy = 17'h10000;
    else wy = {1'b0, in_lane[1].q};
  end

  // stage 1: g * w
  logic v1;
  carry_t c1;
  logic signed [49:0] gwpx1, gwpy1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= in_carry;
      gwpx1 <= in_carry.gx * $signed({1'b0, wx});
      gwpy1 <= in_carry.gy * $signed({1'b0, wy});
    end
  end

  // stage 2: round, then times dt^2
  logic signed [49:0] rx, ry;
  logic signed [33:0] gwx, gwy;
  logic signed [19:0] dt2_s;
  assign rx    = (gwpx1 + 50'sd32768) >>> 16;
  assign ry    = (gwpy1 + 50'sd32768) >>> 16;
  assign gwx   = rx[33:0];
  assign gwy   = ry[33:0];
  assign dt2_s = $signed({1'b0, dt2});

  logic v2;
  carry_t c2;
  logic signed [53:0] gdx2, gdy2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2   <= c1;
      gdx2 <= gwx * dt2_s;
      gdy2 <= gwy * dt2_s;
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {1'b0, c2.cav, c2.warm_a, c2.inert_y, c2.inert_x, c2.warm_a,
                   sat_round(56'(c2.base_y) + 56'(gdy2)),
                   sat_round(56'(c2.base_x) + 56'(gdx2))};
      out_last <= c2.last;
    end
  end

endmodule
